// ----- rtl/scl_pkg.sv -----
`timescale 1ns / 1ps

package scl_pkg;

	// Longest line that is counted; the column sticks at the last counted place.
	localparam int MAX_LINE = 256;
	localparam logic [7:0] COL_MAX = 8'((MAX_LINE > 256) ? 255 : MAX_LINE - 1);

	// Depth of the queue between the lexer and the output stage.
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);
	localparam int QCW    = $clog2(QDEPTH + 1);

	localparam logic [31:0] INT_TOP = 32'h7FFF_FFFF;
	localparam logic [31:0] INT_SAT = 32'h8000_0000;

	// Source bytes with a meaning of their own.
	localparam logic [7:0] CH_NUL        = 8'h00;
	localparam logic [7:0] CH_TAB        = 8'h09;
	localparam logic [7:0] CH_NL         = 8'h0A;
	localparam logic [7:0] CH_CR         = 8'h0D;
	localparam logic [7:0] CH_SPACE      = 8'h20;
	localparam logic [7:0] CH_BANG       = 8'h21;
	localparam logic [7:0] CH_DQUOTE     = 8'h22;
	localparam logic [7:0] CH_PERCENT    = 8'h25;
	localparam logic [7:0] CH_AMP        = 8'h26;
	localparam logic [7:0] CH_SQUOTE     = 8'h27;
	localparam logic [7:0] CH_LPAREN     = 8'h28;
	localparam logic [7:0] CH_RPAREN     = 8'h29;
	localparam logic [7:0] CH_STAR       = 8'h2A;
	localparam logic [7:0] CH_PLUS       = 8'h2B;
	localparam logic [7:0] CH_COMMA      = 8'h2C;
	localparam logic [7:0] CH_MINUS      = 8'h2D;
	localparam logic [7:0] CH_SLASH      = 8'h2F;
	localparam logic [7:0] CH_ZERO       = 8'h30;
	localparam logic [7:0] CH_NINE       = 8'h39;
	localparam logic [7:0] CH_COLON      = 8'h3A;
	localparam logic [7:0] CH_SEMI       = 8'h3B;
	localparam logic [7:0] CH_LT         = 8'h3C;
	localparam logic [7:0] CH_EQ         = 8'h3D;
	localparam logic [7:0] CH_GT         = 8'h3E;
	localparam logic [7:0] CH_UPPER_A    = 8'h41;
	localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
	localparam logic [7:0] CH_LBRACK     = 8'h5B;
	localparam logic [7:0] CH_BSLASH     = 8'h5C;
	localparam logic [7:0] CH_RBRACK     = 8'h5D;
	localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
	localparam logic [7:0] CH_LOWER_A    = 8'h61;
	localparam logic [7:0] CH_LOWER_N    = 8'h6E;
	localparam logic [7:0] CH_LOWER_T    = 8'h74;
	localparam logic [7:0] CH_LOWER_Z    = 8'h7A;
	localparam logic [7:0] CH_LBRACE     = 8'h7B;
	localparam logic [7:0] CH_BAR        = 8'h7C;
	localparam logic [7:0] CH_RBRACE     = 8'h7D;

	typedef enum logic [3:0] {
		M_IDLE,
		M_IDENT,
		M_INT,
		M_STR,
		M_COPEN,
		M_CESC,
		M_CCLOSE,
		M_OP,
		M_SKIP
	} mode_t;

	typedef enum logic [4:0] {
		TK_IDENT, TK_STRING, TK_INT, TK_CHAR, TK_SEMI, TK_LPAREN, TK_RPAREN,
		TK_LBRACE, TK_RBRACE, TK_LBRACK, TK_RBRACK, TK_ARROW, TK_MINUS, TK_SLASH,
		TK_PLUS, TK_STAR, TK_COMMA, TK_EQEQ, TK_ASSIGN, TK_COLON, TK_GE, TK_GT,
		TK_LE, TK_LT, TK_NE, TK_OROR, TK_OR, TK_ANDAND, TK_AND, TK_PERCENT
	} kind_t;

	typedef enum logic [2:0] {
		ERR_NONE,
		ERR_UNKNOWN,
		ERR_CHAR,
		ERR_STRING,
		ERR_OVERFLOW
	} err_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  column;
		logic [30:0] ival;
		logic [7:0]  cval;
		err_t        err;
	} res_t;

	// All results caused by one byte: one or two, on the same line.
	typedef struct packed {
		logic [15:0] line;
		logic        two;
		res_t        r0;
		res_t        r1;
	} bundle_t;

	function automatic res_t mk_res(kind_t kind, logic [7:0] column, logic [30:0] ival,
			logic [7:0] cval, err_t err);
		res_t r;
		r.kind   = kind;
		r.column = column;
		r.ival   = ival;
		r.cval   = cval;
		r.err    = err;
		return r;
	endfunction

	function automatic logic is_alpha(logic [7:0] c);
		return (c >= CH_LOWER_A && c <= CH_LOWER_Z) || (c >= CH_UPPER_A && c <= CH_UPPER_Z);
	endfunction

	function automatic logic is_digit(logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	function automatic logic is_space(logic [7:0] c);
		return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
	endfunction

	// Bytes that may start a one- or two-byte operator.
	function automatic logic is_op_char(logic [7:0] c);
		return c == CH_MINUS || c == CH_SLASH || c == CH_EQ || c == CH_GT ||
			c == CH_LT || c == CH_BANG || c == CH_BAR || c == CH_AMP;
	endfunction

	function automatic logic is_punct(logic [7:0] c);
		return c == CH_SEMI || c == CH_LPAREN || c == CH_RPAREN || c == CH_LBRACE ||
			c == CH_RBRACE || c == CH_LBRACK || c == CH_RBRACK || c == CH_PLUS ||
			c == CH_STAR || c == CH_COMMA || c == CH_COLON || c == CH_PERCENT;
	endfunction

	function automatic kind_t punct_kind(logic [7:0] c);
		kind_t k;
		unique case (c)
			CH_SEMI:    k = TK_SEMI;
			CH_LPAREN:  k = TK_LPAREN;
			CH_RPAREN:  k = TK_RPAREN;
			CH_LBRACE:  k = TK_LBRACE;
			CH_RBRACE:  k = TK_RBRACE;
			CH_LBRACK:  k = TK_LBRACK;
			CH_RBRACK:  k = TK_RBRACK;
			CH_PLUS:    k = TK_PLUS;
			CH_STAR:    k = TK_STAR;
			CH_COMMA:   k = TK_COMMA;
			CH_COLON:   k = TK_COLON;
			CH_PERCENT: k = TK_PERCENT;
			default:    k = TK_IDENT;
		endcase
		return k;
	endfunction

	// One-byte meaning of a held operator byte; a lone bang is an error.
	function automatic res_t single_op(logic [7:0] p, logic [7:0] start);
		res_t r;
		r = mk_res(TK_IDENT, start, '0, '0, ERR_NONE);
		unique case (p)
			CH_MINUS: r.kind = TK_MINUS;
			CH_SLASH: r.kind = TK_SLASH;
			CH_EQ:    r.kind = TK_ASSIGN;
			CH_GT:    r.kind = TK_GT;
			CH_LT:    r.kind = TK_LT;
			CH_BAR:   r.kind = TK_OR;
			CH_AMP:   r.kind = TK_AND;
			default:  r.err  = ERR_UNKNOWN;
		endcase
		return r;
	endfunction

	function automatic res_t int_res(logic [31:0] acc, logic [7:0] start);
		res_t r;
		if (acc > INT_TOP) begin
			r = mk_res(TK_INT, start, INT_TOP[30:0], '0, ERR_OVERFLOW);
		end else begin
			r = mk_res(TK_INT, start, acc[30:0], '0, ERR_NONE);
		end
		return r;
	endfunction

endpackage

// ----- rtl/scl_char_if.sv -----
`timescale 1ns / 1ps

interface scl_char_if;
	logic        valid;
	logic        ready;
	logic [7:0]  ch;
	logic [15:0] line_number;
	logic        line_last;

	modport source(output valid, ch, line_number, line_last, input ready);
	modport sink(input valid, ch, line_number, line_last, output ready);
endinterface

// ----- rtl/scl_token_if.sv -----
`timescale 1ns / 1ps

interface scl_token_if;
	logic        valid;
	logic        ready;
	logic [4:0]  token_kind;
	logic [15:0] token_line;
	logic [7:0]  token_column;
	logic [30:0] int_value;
	logic [7:0]  char_value;
	logic [2:0]  error_kind;
	logic        result_last;

	modport source(output valid, token_kind, token_line, token_column, int_value,
		char_value, error_kind, result_last, input ready);
	modport sink(input valid, token_kind, token_line, token_column, int_value,
		char_value, error_kind, result_last, output ready);
endinterface

// ----- rtl/scl_front.sv -----
`timescale 1ns / 1ps

module scl_front (
	input  logic              clk,
	input  logic              arst_n,
	scl_char_if.sink          chars,
	input  logic              full,
	output logic              push,
	output scl_pkg::bundle_t  bundle
);

	scl_pkg::mode_t mode_q;
	logic [7:0]     col_q;
	logic [7:0]     start_q;
	logic [31:0]    accum_q;
	logic [7:0]     pend_q;

	scl_pkg::mode_t mode_d;
	logic [7:0]     col_d;
	logic [7:0]     start_d;
	logic [31:0]    accum_d;
	logic [7:0]     pend_d;

	logic           accept;
	logic [7:0]     c;
	logic [7:0]     col;

	scl_pkg::res_t  ep, ei, ef;
	logic           ep_v, ei_v, ef_v;
	logic           do_idle;
	logic [35:0]    prod;
	scl_pkg::kind_t pair_k;
	logic           pair_v;

	assign chars.ready = !full;
	assign accept      = chars.valid && chars.ready;
	assign c           = chars.ch;
	assign col         = col_q;

	// Accumulate the next decimal digit; shift-and-add for the times ten.
	assign prod = ({4'b0, accum_q} << 3) + ({4'b0, accum_q} << 1) + 36'(c[3:0]);

	always_comb begin
		mode_d  = mode_q;
		start_d = start_q;
		accum_d = accum_q;
		pend_d  = pend_q;
		ep      = '0;
		ei      = '0;
		ef      = '0;
		ep_v    = 1'b0;
		ei_v    = 1'b0;
		ef_v    = 1'b0;
		do_idle = 1'b0;
		pair_v  = 1'b1;
		pair_k  = scl_pkg::TK_IDENT;

		// Two-byte operator match for a held operator byte.
		if (pend_q == scl_pkg::CH_MINUS && c == scl_pkg::CH_GT) begin
			pair_k = scl_pkg::TK_ARROW;
		end else if (pend_q == scl_pkg::CH_EQ && c == scl_pkg::CH_EQ) begin
			pair_k = scl_pkg::TK_EQEQ;
		end else if (pend_q == scl_pkg::CH_GT && c == scl_pkg::CH_EQ) begin
			pair_k = scl_pkg::TK_GE;
		end else if (pend_q == scl_pkg::CH_LT && c == scl_pkg::CH_EQ) begin
			pair_k = scl_pkg::TK_LE;
		end else if (pend_q == scl_pkg::CH_BANG && c == scl_pkg::CH_EQ) begin
			pair_k = scl_pkg::TK_NE;
		end else if (pend_q == scl_pkg::CH_BAR && c == scl_pkg::CH_BAR) begin
			pair_k = scl_pkg::TK_OROR;
		end else if (pend_q == scl_pkg::CH_AMP && c == scl_pkg::CH_AMP) begin
			pair_k = scl_pkg::TK_ANDAND;
		end else begin
			pair_v = 1'b0;
		end

		unique case (mode_q)
			scl_pkg::M_IDLE: begin
				do_idle = 1'b1;
			end
			scl_pkg::M_IDENT: begin
				if (scl_pkg::is_alpha(c) || scl_pkg::is_digit(c) ||
						c == scl_pkg::CH_UNDERSCORE) begin
					start_d = col;
				end else begin
					ep      = scl_pkg::mk_res(scl_pkg::TK_IDENT, start_q, '0, '0,
						scl_pkg::ERR_NONE);
					ep_v    = 1'b1;
					do_idle = 1'b1;
				end
			end
			scl_pkg::M_INT: begin
				if (scl_pkg::is_digit(c)) begin
					start_d = col;
					accum_d = (prod > 36'(scl_pkg::INT_TOP)) ? scl_pkg::INT_SAT : prod[31:0];
				end else begin
					ep   = scl_pkg::int_res(accum_q, start_q);
					ep_v = 1'b1;
					if (accum_q > scl_pkg::INT_TOP) begin
						mode_d = scl_pkg::M_SKIP;
					end else begin
						do_idle = 1'b1;
					end
				end
			end
			scl_pkg::M_STR: begin
				if (c == scl_pkg::CH_DQUOTE) begin
					ep     = scl_pkg::mk_res(scl_pkg::TK_STRING, col, '0, '0,
						scl_pkg::ERR_NONE);
					ep_v   = 1'b1;
					mode_d = scl_pkg::M_IDLE;
				end else begin
					start_d = col;
				end
			end
			scl_pkg::M_COPEN: begin
				if (c == scl_pkg::CH_BSLASH) begin
					mode_d = scl_pkg::M_CESC;
				end else begin
					pend_d = c;
					mode_d = scl_pkg::M_CCLOSE;
				end
			end
			scl_pkg::M_CESC: begin
				mode_d = scl_pkg::M_CCLOSE;
				if (c == scl_pkg::CH_LOWER_N) begin
					pend_d = scl_pkg::CH_NL;
				end else if (c == scl_pkg::CH_BSLASH) begin
					pend_d = scl_pkg::CH_BSLASH;
				end else if (c == scl_pkg::CH_LOWER_T) begin
					pend_d = scl_pkg::CH_TAB;
				end else if (c == scl_pkg::CH_ZERO) begin
					pend_d = scl_pkg::CH_NUL;
				end else begin
					ep     = scl_pkg::mk_res(scl_pkg::TK_CHAR, start_q, '0, '0,
						scl_pkg::ERR_CHAR);
					ep_v   = 1'b1;
					mode_d = scl_pkg::M_SKIP;
				end
			end
			scl_pkg::M_CCLOSE: begin
				ep_v = 1'b1;
				if (c == scl_pkg::CH_SQUOTE) begin
					ep     = scl_pkg::mk_res(scl_pkg::TK_CHAR, start_q, '0, pend_q,
						scl_pkg::ERR_NONE);
					mode_d = scl_pkg::M_IDLE;
				end else begin
					ep     = scl_pkg::mk_res(scl_pkg::TK_CHAR, start_q, '0, '0,
						scl_pkg::ERR_CHAR);
					mode_d = scl_pkg::M_SKIP;
				end
			end
			scl_pkg::M_OP: begin
				if (pair_v) begin
					ep     = scl_pkg::mk_res(pair_k, start_q, '0, '0, scl_pkg::ERR_NONE);
					ep_v   = 1'b1;
					mode_d = scl_pkg::M_IDLE;
				end else if (pend_q == scl_pkg::CH_SLASH && c == scl_pkg::CH_SLASH) begin
					mode_d = scl_pkg::M_SKIP;
				end else begin
					ep   = scl_pkg::single_op(pend_q, start_q);
					ep_v = 1'b1;
					if (ep.err != scl_pkg::ERR_NONE) begin
						mode_d = scl_pkg::M_SKIP;
					end else begin
						do_idle = 1'b1;
					end
				end
			end
			scl_pkg::M_SKIP: begin
				mode_d = scl_pkg::M_SKIP;
			end
			default: begin
				mode_d = scl_pkg::M_SKIP;
			end
		endcase

		// Byte seen between tokens: skip a space, open a token, emit a one-byte one, or flag an unknown byte.
		if (do_idle) begin
			mode_d = scl_pkg::M_IDLE;
			if (scl_pkg::is_space(c)) begin
				mode_d = scl_pkg::M_IDLE;
			end else if (scl_pkg::is_alpha(c)) begin
				mode_d  = scl_pkg::M_IDENT;
				start_d = col;
			end else if (scl_pkg::is_digit(c)) begin
				mode_d  = scl_pkg::M_INT;
				start_d = col;
				accum_d = 32'(c[3:0]);
			end else if (c == scl_pkg::CH_DQUOTE) begin
				mode_d  = scl_pkg::M_STR;
				start_d = col;
			end else if (c == scl_pkg::CH_SQUOTE) begin
				mode_d  = scl_pkg::M_COPEN;
				start_d = col;
			end else if (scl_pkg::is_punct(c)) begin
				ei   = scl_pkg::mk_res(scl_pkg::punct_kind(c), col, '0, '0, scl_pkg::ERR_NONE);
				ei_v = 1'b1;
			end else if (scl_pkg::is_op_char(c)) begin
				mode_d  = scl_pkg::M_OP;
				pend_d  = c;
				start_d = col;
			end else begin
				ei     = scl_pkg::mk_res(scl_pkg::TK_IDENT, col, '0, '0, scl_pkg::ERR_UNKNOWN);
				ei_v   = 1'b1;
				mode_d = scl_pkg::M_SKIP;
			end
		end

		// Line end: flush the open token, then return to the reset state.
		if (chars.line_last) begin
			ef_v = 1'b1;
			case (mode_d)
				scl_pkg::M_IDENT: ef = scl_pkg::mk_res(scl_pkg::TK_IDENT, start_d, '0, '0,
					scl_pkg::ERR_NONE);
				scl_pkg::M_INT: ef = scl_pkg::int_res(accum_d, start_d);
				scl_pkg::M_STR: ef = scl_pkg::mk_res(scl_pkg::TK_STRING, start_d, '0, '0,
					scl_pkg::ERR_STRING);
				scl_pkg::M_COPEN, scl_pkg::M_CESC, scl_pkg::M_CCLOSE:
					ef = scl_pkg::mk_res(scl_pkg::TK_CHAR, start_d, '0, '0, scl_pkg::ERR_CHAR);
				scl_pkg::M_OP: ef = scl_pkg::single_op(pend_d, start_d);
				default: ef_v = 1'b0;
			endcase
			mode_d  = scl_pkg::M_IDLE;
			start_d = '0;
			accum_d = '0;
			pend_d  = '0;
		end
	end

	always_comb begin
		if (chars.line_last) begin
			col_d = '0;
		end else if (col_q < scl_pkg::COL_MAX) begin
			col_d = col_q + 8'd1;
		end else begin
			col_d = col_q;
		end
	end

	// Pack the results in order; a byte never causes more than two.
	always_comb begin
		bundle.line = chars.line_number;
		bundle.two  = (ep_v && ei_v) || (ep_v && ef_v) || (ei_v && ef_v);
		bundle.r0   = ep_v ? ep : (ei_v ? ei : ef);
		bundle.r1   = (ep_v && ei_v) ? ei : ef;
	end

	assign push = accept && (ep_v || ei_v || ef_v);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= scl_pkg::M_IDLE;
			col_q   <= '0;
			start_q <= '0;
			accum_q <= '0;
			pend_q  <= '0;
		end else if (accept) begin
			mode_q  <= mode_d;
			col_q   <= col_d;
			start_q <= start_d;
			accum_q <= accum_d;
			pend_q  <= pend_d;
		end
	end

`ifndef SYNTH
	a_line_end_clears : assert property (@(posedge clk) disable iff (!arst_n)
		accept && chars.line_last |=> mode_q == scl_pkg::M_IDLE && col_q == '0)
		else $error("lexer state not cleared after line end");
`endif

endmodule

// ----- rtl/scl_queue.sv -----
`timescale 1ns / 1ps

module scl_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  scl_pkg::bundle_t  wdata,
	output logic              full,
	input  logic              pop,
	output logic              empty,
	output scl_pkg::bundle_t  head
);

	scl_pkg::bundle_t              mem [scl_pkg::QDEPTH];
	logic [scl_pkg::QAW-1:0]       wr_q;
	logic [scl_pkg::QAW-1:0]       rd_q;
	logic [scl_pkg::QCW-1:0]       cnt_q;

	assign full  = cnt_q == scl_pkg::QCW'(scl_pkg::QDEPTH);
	assign empty = cnt_q == '0;
	assign head  = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == scl_pkg::QAW'(scl_pkg::QDEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == scl_pkg::QAW'(scl_pkg::QDEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

`ifndef SYNTH
	a_no_overrun : assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("queue written while full");
	a_no_underrun : assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("queue read while empty");
`endif

endmodule

// ----- rtl/scl_back.sv -----
`timescale 1ns / 1ps

module scl_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              empty,
	input  scl_pkg::bundle_t  head,
	output logic              pop,
	scl_token_if.source       tokens
);

	scl_pkg::bundle_t hold_q;
	logic             hv_q;
	logic             sel_q;
	scl_pkg::res_t    cur;
	logic             out_last;
	logic             out_acc;

	assign cur      = sel_q ? hold_q.r1 : hold_q.r0;
	assign out_last = sel_q || !hold_q.two;
	assign out_acc  = tokens.valid && tokens.ready;
	assign pop      = !empty && (!hv_q || (out_acc && out_last));

	assign tokens.valid        = hv_q;
	assign tokens.token_kind   = cur.kind;
	assign tokens.token_line   = hold_q.line;
	assign tokens.token_column = cur.column;
	assign tokens.int_value    = cur.ival;
	assign tokens.char_value   = cur.cval;
	assign tokens.error_kind   = cur.err;
	assign tokens.result_last  = out_last;

	always_ff @(posedge clk) begin
		if (pop) begin
			hold_q <= head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hv_q  <= 1'b0;
			sel_q <= 1'b0;
		end else if (pop) begin
			hv_q  <= 1'b1;
			sel_q <= 1'b0;
		end else if (out_acc) begin
			hv_q  <= !out_last;
			sel_q <= !out_last;
		end
	end

`ifndef SYNTH
	a_second_only_if_two : assert property (@(posedge clk) disable iff (!arst_n)
		sel_q |-> hv_q && hold_q.two)
		else $error("second result shown for a single-result request");
`endif

endmodule

// ----- rtl/source_char_lexer_unit.sv -----
`timescale 1ns / 1ps
// Path: a byte's results are written to the queue when the byte is accepted and are moved
//   into the output register before they are offered.
// Throughput: one byte per cycle while the queue is not full; a byte that causes two
//   tokens holds the output for both, as the port moves one token per cycle when ready.
// A four-entry queue between the lexer and the output register absorbs such bursts.
// Reset: the lexer returns to idle at column zero and the queue and output empty at once.

module source_char_lexer_unit (
	input  logic          clk,
	input  logic          arst_n,
	scl_char_if.sink      chars,
	scl_token_if.source   tokens
);

	// Front to queue: one bundle of results per source byte that causes any.
	logic             push;
	logic             full;
	scl_pkg::bundle_t wbundle;

	// Queue to output stage.
	logic             pop;
	logic             empty;
	scl_pkg::bundle_t head;

	// Classify each byte and track the open token; stall only when the queue is full.
	scl_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars),
		.full   (full),
		.push   (push),
		.bundle (wbundle)
	);

	// Hold pending bundles so the lexer keeps running while the output is stalled.
	scl_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (wbundle),
		.full   (full),
		.pop    (pop),
		.empty  (empty),
		.head   (head)
	);

	// Register each bundle and hand its tokens out one request at a time,
	// marking the last one caused by its byte.
	scl_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.empty  (empty),
		.head   (head),
		.pop    (pop),
		.tokens (tokens)
	);

endmodule
